// File: rtl/tksh_pkg.sv
// shared types, command codes and constants for the top-k score heap
// no dependencies

package tksh_pkg;

  localparam int unsigned SCORE_W  = 32;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned COUNT_W  = 12;
  localparam int unsigned CAPACITY = 2048;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 12'd2000;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic               accepted;
    logic               out_valid;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
  } res_t;

  // signed compare a < b
  function automatic logic score_less(input logic [SCORE_W-1:0] a,
                                      input logic [SCORE_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// File: rtl/tksh_bank.sv
// one heap memory bank: one write port, one read port, registered read data
// depends on tksh_pkg

module tksh_bank #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  tksh_pkg::entry_t wr_data_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output tksh_pkg::entry_t rd_data_o
);

  tksh_pkg::entry_t mem_q [DEPTH];
  tksh_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/tksh_ctrl.sv
// heap sequencer: insert with sift up, replace root and pop with sift down, clear
// depends on tksh_pkg; drives two tksh_bank memories (odd and even heap indices)

module tksh_ctrl #(
  parameter int unsigned BAW = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [tksh_pkg::SCORE_W-1:0]  score_i,
  input  logic [tksh_pkg::TAG_W-1:0]    tag_i,
  input  logic [tksh_pkg::COUNT_W-1:0]  limit_i,
  output logic                          b0_wr_en_o,
  output logic [BAW-1:0]                b0_wr_addr_o,
  output logic                          b0_rd_en_o,
  output logic [BAW-1:0]                b0_rd_addr_o,
  input  tksh_pkg::entry_t              b0_rd_data_i,
  output logic                          b1_wr_en_o,
  output logic [BAW-1:0]                b1_wr_addr_o,
  output logic                          b1_rd_en_o,
  output logic [BAW-1:0]                b1_rd_addr_o,
  input  tksh_pkg::entry_t              b1_rd_data_i,
  output tksh_pkg::entry_t              wr_data_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output tksh_pkg::res_t                res_o
);

  localparam int unsigned AW = (tksh_pkg::CAPACITY > 1) ? $clog2(tksh_pkg::CAPACITY) : 1;
  localparam int unsigned IW = (AW + 2 > tksh_pkg::COUNT_W + 1) ? AW + 2
                                                                : tksh_pkg::COUNT_W + 1;
  localparam logic [IW-1:0] CAP_W = IW'(tksh_pkg::CAPACITY);
  localparam logic [IW-1:0] ONE_W = IW'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SU_CHK,
    ST_SU_CMP,
    ST_INS_RD,
    ST_INS_CMP,
    ST_POP_RD,
    ST_POP_LAST,
    ST_POP_GET,
    ST_SD_CHK,
    ST_SD_CMP,
    ST_DONE
  } state_e;

  state_e                         state_q;
  logic [tksh_pkg::COUNT_W-1:0]   cnt_q;
  logic [IW-1:0]                  pos_q;
  logic [IW-1:0]                  par_q;
  tksh_pkg::entry_t               val_q;
  tksh_pkg::entry_t               out_q;
  logic                           acc_q;
  logic                           outv_q;
  logic                           rd_bank_q;

  logic [IW-1:0]     cnt_w;
  logic              room;
  logic [IW-1:0]     parent;
  logic [IW-1:0]     child_l;
  logic [IW-1:0]     child_r;
  logic [IW-1:0]     pos_inc;
  logic              pick_r;
  tksh_pkg::entry_t  pick;
  logic [IW-1:0]     pick_idx;
  tksh_pkg::entry_t  sel;

  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  tksh_pkg::entry_t  wr_dat;
  logic              rd_en;
  logic              rd_pair;
  logic [IW-1:0]     rd_idx;

  assign cnt_w   = {{(IW-tksh_pkg::COUNT_W){1'b0}}, cnt_q};
  assign room    = (cnt_w < {{(IW-tksh_pkg::COUNT_W){1'b0}}, limit_i}) && (cnt_w < CAP_W);
  assign parent  = (pos_q - ONE_W) >> 1;
  assign child_l = {pos_q[IW-2:0], 1'b1};
  assign child_r = child_l + ONE_W;
  assign pos_inc = pos_q + ONE_W;
  assign sel     = rd_bank_q ? b1_rd_data_i : b0_rd_data_i;

  // left child sits in the odd bank, right child in the even bank
  assign pick_r   = (child_r < cnt_w) &&
                    tksh_pkg::score_less(b0_rd_data_i.score, b1_rd_data_i.score);
  assign pick     = pick_r ? b0_rd_data_i : b1_rd_data_i;
  assign pick_idx = pick_r ? child_r : child_l;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = pos_q;
    wr_dat  = val_q;
    rd_en   = 1'b0;
    rd_pair = 1'b0;
    rd_idx  = '0;
    case (state_q)
      ST_SU_CHK: begin
        if (pos_q == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en  = 1'b1;
          rd_idx = parent;
        end
      end
      ST_SU_CMP: begin
        wr_en = 1'b1;
        if (tksh_pkg::score_less(val_q.score, sel.score)) begin
          wr_dat = sel;
        end
      end
      ST_INS_RD, ST_POP_RD: begin
        rd_en = 1'b1;
      end
      ST_POP_LAST: begin
        if (cnt_q != '0) begin
          rd_en  = 1'b1;
          rd_idx = cnt_w;
        end
      end
      ST_SD_CHK: begin
        if (child_l >= cnt_w) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_pair = 1'b1;
        end
      end
      ST_SD_CMP: begin
        wr_en = 1'b1;
        if (tksh_pkg::score_less(pick.score, val_q.score)) begin
          wr_dat = pick;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign b0_wr_en_o   = wr_en & ~wr_idx[0];
  assign b1_wr_en_o   = wr_en & wr_idx[0];
  assign b0_wr_addr_o = wr_idx[BAW:1];
  assign b1_wr_addr_o = wr_idx[BAW:1];
  assign wr_data_o    = wr_dat;

  assign b0_rd_en_o   = rd_en & (rd_pair | ~rd_idx[0]);
  assign b1_rd_en_o   = rd_en & (rd_pair | rd_idx[0]);
  assign b0_rd_addr_o = rd_pair ? pos_inc[BAW-1:0] : rd_idx[BAW:1];
  assign b1_rd_addr_o = rd_pair ? pos_q[BAW-1:0]   : rd_idx[BAW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pos_q     <= '0;
      par_q     <= '0;
      acc_q     <= 1'b0;
      outv_q    <= 1'b0;
      rd_bank_q <= 1'b0;
      val_q     <= '0;
      out_q     <= '0;
    end else begin
      if (rd_en && !rd_pair) begin
        rd_bank_q <= rd_idx[0];
      end
      case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            acc_q     <= 1'b0;
            outv_q    <= 1'b0;
            out_q     <= '0;
            val_q     <= '{score: score_i, tag: tag_i};
            case (tksh_pkg::cmd_e'(command_i))
              tksh_pkg::CMD_INSERT: begin
                if (room) begin
                  pos_q   <= cnt_w;
                  cnt_q   <= cnt_q + 1'b1;
                  acc_q   <= 1'b1;
                  state_q <= ST_SU_CHK;
                end else if (limit_i != '0 && cnt_q != '0) begin
                  state_q <= ST_INS_RD;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              tksh_pkg::CMD_POP: begin
                if (cnt_q != '0) begin
                  cnt_q   <= cnt_q - 1'b1;
                  state_q <= ST_POP_RD;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              tksh_pkg::CMD_CLEAR: begin
                cnt_q   <= '0;
                state_q <= ST_DONE;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_SU_CHK: begin
          if (pos_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            par_q   <= parent;
            state_q <= ST_SU_CMP;
          end
        end
        ST_SU_CMP: begin
          if (tksh_pkg::score_less(val_q.score, sel.score)) begin
            pos_q   <= par_q;
            state_q <= ST_SU_CHK;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_INS_RD: begin
          state_q <= ST_INS_CMP;
        end
        ST_INS_CMP: begin
          if (tksh_pkg::score_less(sel.score, val_q.score)) begin
            acc_q   <= 1'b1;
            pos_q   <= '0;
            state_q <= ST_SD_CHK;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_POP_RD: begin
          state_q <= ST_POP_LAST;
        end
        ST_POP_LAST: begin
          out_q  <= sel;
          outv_q <= 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_POP_GET;
          end
        end
        ST_POP_GET: begin
          val_q   <= sel;
          pos_q   <= '0;
          state_q <= ST_SD_CHK;
        end
        ST_SD_CHK: begin
          if (child_l >= cnt_w) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SD_CMP;
          end
        end
        ST_SD_CMP: begin
          if (tksh_pkg::score_less(pick.score, val_q.score)) begin
            pos_q   <= pick_idx;
            state_q <= ST_SD_CHK;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_stall_o = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = '{accepted:  acc_q,
                         out_valid: outv_q,
                         score:     out_q.score,
                         tag:       out_q.tag,
                         count:     cnt_q};

endmodule

// File: rtl/top_k_score_heap_top.sv
// top level of the bounded top-k min-heap: limit register, result register, banks
// depends on tksh_pkg, tksh_bank, tksh_ctrl
//
//  channel  handshake                  payload
//  req      req_valid_i / req_stall_o  command_i, score_i, tag_i
//  res      res_valid_o / res_stall_i  accepted_o, out_valid_o, out_score_o,
//                                      out_tag_o, entry_count_o
//  cfg      cfg_valid_i / cfg_ready_o  cfg_data_i (heap_limit)
//
// one request at a time; heap entries split over two registered-read banks (odd/even
// index) so both children of a node are read together
// insert with room sifts up level by level; replace root reads and compares the root, then sifts down;
// pop reads the root and the last entry, then sifts down if entries remain; each request ends in done, then idle
// reset empties the heap and sets the limit to 2000; heap memory is not cleared
// a finished result waits in the result register while the next request is accepted

module top_k_score_heap_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_stall_o,
  input  logic [1:0]                        command_i,
  input  logic signed [tksh_pkg::SCORE_W-1:0] score_i,
  input  logic [tksh_pkg::TAG_W-1:0]        tag_i,
  output logic                              res_valid_o,
  input  logic                              res_stall_i,
  output logic                              accepted_o,
  output logic                              out_valid_o,
  output logic signed [tksh_pkg::SCORE_W-1:0] out_score_o,
  output logic [tksh_pkg::TAG_W-1:0]        out_tag_o,
  output logic [tksh_pkg::COUNT_W-1:0]      entry_count_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tksh_pkg::COUNT_W-1:0]      cfg_data_i
);

  localparam int unsigned BD  = (tksh_pkg::CAPACITY + 1) / 2;
  localparam int unsigned BAW = (BD > 1) ? $clog2(BD) : 1;

  logic [tksh_pkg::COUNT_W-1:0] limit_q;
  tksh_pkg::res_t               res_q;
  logic                         res_valid_q;

  logic             b0_wr_en, b1_wr_en, b0_rd_en, b1_rd_en;
  logic [BAW-1:0]   b0_wr_addr, b1_wr_addr, b0_rd_addr, b1_rd_addr;
  tksh_pkg::entry_t b0_rd_data, b1_rd_data, wr_data;
  logic             done;
  logic             slot_free;
  tksh_pkg::res_t   ctrl_res;

  assign cfg_ready_o = 1'b1;
  assign slot_free   = !res_valid_q || !res_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tksh_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (done && slot_free) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && slot_free) begin
      res_q <= ctrl_res;
    end
  end

  tksh_bank #(.DEPTH(BD), .AW(BAW)) u_bank_even (
    .clk_i     (clk_i),
    .wr_en_i   (b0_wr_en),
    .wr_addr_i (b0_wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (b0_rd_en),
    .rd_addr_i (b0_rd_addr),
    .rd_data_o (b0_rd_data)
  );

  tksh_bank #(.DEPTH(BD), .AW(BAW)) u_bank_odd (
    .clk_i     (clk_i),
    .wr_en_i   (b1_wr_en),
    .wr_addr_i (b1_wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (b1_rd_en),
    .rd_addr_i (b1_rd_addr),
    .rd_data_o (b1_rd_data)
  );

  tksh_ctrl #(.BAW(BAW)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_stall_o  (req_stall_o),
    .command_i    (command_i),
    .score_i      (score_i),
    .tag_i        (tag_i),
    .limit_i      (limit_q),
    .b0_wr_en_o   (b0_wr_en),
    .b0_wr_addr_o (b0_wr_addr),
    .b0_rd_en_o   (b0_rd_en),
    .b0_rd_addr_o (b0_rd_addr),
    .b0_rd_data_i (b0_rd_data),
    .b1_wr_en_o   (b1_wr_en),
    .b1_wr_addr_o (b1_wr_addr),
    .b1_rd_en_o   (b1_rd_en),
    .b1_rd_addr_o (b1_rd_addr),
    .b1_rd_data_i (b1_rd_data),
    .wr_data_o    (wr_data),
    .res_valid_o  (done),
    .res_ready_i  (slot_free),
    .res_o        (ctrl_res)
  );

  assign res_valid_o   = res_valid_q;
  assign accepted_o    = res_q.accepted;
  assign out_valid_o   = res_q.out_valid;
  assign out_score_o   = res_q.score;
  assign out_tag_o     = res_q.tag;
  assign entry_count_o = res_q.count;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for top_k_score_heap_top: directed and random heap requests
// checked against an in-bench bounded top-k heap predictor
// depends on tksh_pkg and the rtl under rtl/

module tb_top;

  localparam int unsigned SCORE_W       = tksh_pkg::SCORE_W;
  localparam int unsigned TAG_W         = tksh_pkg::TAG_W;
  localparam int unsigned COUNT_W       = tksh_pkg::COUNT_W;
  localparam int unsigned DEPTH         = tksh_pkg::CAPACITY;
  localparam int unsigned GAP_MAX       = 17;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned HANG_LIMIT    = 1500;
  localparam int unsigned RANDOM_TARGET = 1850;

  typedef struct {
    tksh_pkg::cmd_e     op;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } heap_req_t;

  logic                      clk_i;
  logic                      rst_ni       = 1'b0;
  logic                      req_valid_i  = 1'b0;
  logic                      req_stall_o;
  logic [1:0]                command_i    = tksh_pkg::CMD_NOP;
  logic signed [SCORE_W-1:0] score_i      = '0;
  logic [TAG_W-1:0]          tag_i        = '0;
  logic                      res_valid_o;
  logic                      res_stall_i  = 1'b0;
  logic                      accepted_o;
  logic                      out_valid_o;
  logic signed [SCORE_W-1:0] out_score_o;
  logic [TAG_W-1:0]          out_tag_o;
  logic [COUNT_W-1:0]        entry_count_o;
  logic                      cfg_valid_i  = 1'b0;
  logic                      cfg_ready_o;
  logic [COUNT_W-1:0]        cfg_data_i   = '0;

  top_k_score_heap_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_stall_o  (req_stall_o),
    .command_i    (command_i),
    .score_i      (score_i),
    .tag_i        (tag_i),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .accepted_o   (accepted_o),
    .out_valid_o  (out_valid_o),
    .out_score_o  (out_score_o),
    .out_tag_o    (out_tag_o),
    .entry_count_o(entry_count_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // heap predictor state
  logic [SCORE_W-1:0] heap_key [DEPTH];
  logic [TAG_W-1:0]   heap_tag [DEPTH];
  int unsigned        held_n     = 0;
  int unsigned        kept_limit = tksh_pkg::LIMIT_RESET;
  int unsigned        max_held   = 0;

  heap_req_t       pending_req [$];
  tksh_pkg::res_t  expected_res [$];
  heap_req_t       in_flight;
  int unsigned req_gap    = 0;
  int unsigned sink_wait  = 0;
  bit          quiet_req  = 1'b0;
  bit          quiet_res  = 1'b0;
  int unsigned idle_run   = 0;
  int unsigned err_count  = 0;
  int unsigned req_count  = 0;
  int unsigned res_count  = 0;
  int unsigned kept_count = 0;
  int unsigned pop_hits   = 0;
  int unsigned cfg_writes = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void settle_up(int unsigned pos, logic [SCORE_W-1:0] s,
                                    logic [TAG_W-1:0] t);
    int unsigned up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!($signed(s) < $signed(heap_key[up]))) break;
      heap_key[pos] = heap_key[up];
      heap_tag[pos] = heap_tag[up];
      pos = up;
    end
    heap_key[pos] = s;
    heap_tag[pos] = t;
  endfunction

  // equal children: left one wins
  function automatic void settle_down(int unsigned pos, logic [SCORE_W-1:0] s,
                                      logic [TAG_W-1:0] t);
    int unsigned kid;
    while (2 * pos + 1 < held_n) begin
      kid = 2 * pos + 1;
      if (kid + 1 < held_n && $signed(heap_key[kid + 1]) < $signed(heap_key[kid]))
        kid = kid + 1;
      if (!($signed(heap_key[kid]) < $signed(s))) break;
      heap_key[pos] = heap_key[kid];
      heap_tag[pos] = heap_tag[kid];
      pos = kid;
    end
    heap_key[pos] = s;
    heap_tag[pos] = t;
  endfunction

  function automatic tksh_pkg::res_t heap_outcome(heap_req_t r);
    tksh_pkg::res_t o;
    int unsigned    cap;
    o   = '0;
    cap = (kept_limit > DEPTH) ? DEPTH : kept_limit;
    case (r.op)
      tksh_pkg::CMD_INSERT: begin
        if (held_n < cap) begin
          held_n = held_n + 1;
          settle_up(held_n - 1, r.score, r.tag);
          o.accepted = 1'b1;
        end else if (cap > 0 && held_n > 0 && $signed(heap_key[0]) < $signed(r.score)) begin
          settle_down(0, r.score, r.tag);
          o.accepted = 1'b1;
        end
      end
      tksh_pkg::CMD_POP: begin
        if (held_n > 0) begin
          o.out_valid = 1'b1;
          o.score     = heap_key[0];
          o.tag       = heap_tag[0];
          held_n      = held_n - 1;
          if (held_n > 0) settle_down(0, heap_key[held_n], heap_tag[held_n]);
        end
      end
      tksh_pkg::CMD_CLEAR: held_n = 0;
      default: ;
    endcase
    if (held_n > max_held) max_held = held_n;
    o.count = COUNT_W'(held_n);
    return o;
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    $display("%0t result %0d mismatch: %s", $time, res_count, what);
  endtask

  // request driver
  always @(posedge clk_i) begin
    heap_req_t      nxt;
    tksh_pkg::res_t want;
    if (rst_ni) begin
      if (req_valid_i && !req_stall_o) begin
        want = heap_outcome(in_flight);
        expected_res.insert(expected_res.size(), want);
        req_count++;
        if (want.accepted) kept_count++;
        if (want.out_valid) pop_hits++;
        req_gap = quiet_req ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (!req_valid_i || !req_stall_o) begin
        if (req_gap > 0) begin
          req_gap--;
          req_valid_i <= 1'b0;
        end else if (pending_req.size() > 0) begin
          nxt = pending_req.pop_front();
          in_flight = nxt;
          command_i <= nxt.op;
          score_i <= nxt.score;
          tag_i <= nxt.tag;
          req_valid_i <= 1'b1;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink stalls
  always @(posedge clk_i) begin
    tksh_pkg::res_t want;
    if (rst_ni) begin
      if (res_valid_o && !res_stall_i) begin
        res_count++;
        if (expected_res.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_res.pop_front();
          if (accepted_o !== want.accepted)
            report_mismatch($sformatf("accepted %b, want %b", accepted_o, want.accepted));
          if (out_valid_o !== want.out_valid)
            report_mismatch($sformatf("out_valid %b, want %b", out_valid_o, want.out_valid));
          if (out_score_o !== want.score)
            report_mismatch($sformatf("out_score %h, want %h", out_score_o, want.score));
          if (out_tag_o !== want.tag)
            report_mismatch($sformatf("out_tag %h, want %h", out_tag_o, want.tag));
          if (entry_count_o !== want.count)
            report_mismatch($sformatf("entry_count %0d, want %0d", entry_count_o, want.count));
        end
        sink_wait = quiet_res ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        res_stall_i <= 1'b1;
      end else begin
        res_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid_i && !req_stall_o) || (res_valid_o && !res_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (idle_run < HANG_LIMIT) @(posedge clk_i);
    $display("%0t no handshake for %0d cycles, %0d results outstanding", $time,
             HANG_LIMIT, expected_res.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic add_req(tksh_pkg::cmd_e op, logic [SCORE_W-1:0] s, logic [TAG_W-1:0] t);
    heap_req_t r;
    r.op    = op;
    r.score = s;
    r.tag   = t;
    pending_req.insert(pending_req.size(), r);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_req.size() != 0 || req_valid_i || expected_res.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_limit(logic [COUNT_W-1:0] v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    kept_limit = v;
    cfg_writes++;
    @(negedge clk_i);
  endtask

  function automatic logic [SCORE_W-1:0] rand_score();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    // narrow range so equal scores are common
    if (pick < 5) return SCORE_W'($urandom_range(0, 31)) - 32'd16;
    return $urandom;
  endfunction

  initial begin
    int unsigned    limit_plan [$];
    int unsigned    issued;
    int unsigned    phase;
    int unsigned    n_items;
    int unsigned    pop_pct;
    int unsigned    clear_pct;
    int unsigned    pick;
    tksh_pkg::cmd_e op;

    limit_plan = '{2, 1, 7, 31, 2048, 4095, 0, 16, 500, 3, 2000, 64, 1, 255, 2047, 9};
    issued = 0;
    phase  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset limit, extremes and every command
    add_req(tksh_pkg::CMD_POP, 32'h1234_5678, 32'h9ABC_DEF0);
    add_req(tksh_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_req(tksh_pkg::CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
    add_req(tksh_pkg::CMD_INSERT, 32'h0000_0000, 32'h5A5A_A5A5);
    add_req(tksh_pkg::CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(tksh_pkg::CMD_POP, 32'h0, 32'h0);
    add_req(tksh_pkg::CMD_CLEAR, 32'h0, 32'h0);
    add_req(tksh_pkg::CMD_POP, 32'h0, 32'h0);

    // full heap: equal scores, dropped and replacing inserts
    write_limit(12'd3);
    add_req(tksh_pkg::CMD_INSERT, 32'd10, 32'd1);
    add_req(tksh_pkg::CMD_INSERT, 32'd10, 32'd2);
    add_req(tksh_pkg::CMD_INSERT, 32'd10, 32'd3);
    add_req(tksh_pkg::CMD_INSERT, 32'd10, 32'd4);
    add_req(tksh_pkg::CMD_INSERT, 32'd5, 32'd5);
    add_req(tksh_pkg::CMD_INSERT, 32'd20, 32'd6);

    // limit below the count held
    write_limit(12'd1);
    add_req(tksh_pkg::CMD_INSERT, 32'd11, 32'd7);
    add_req(tksh_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'd8);
    repeat (4) add_req(tksh_pkg::CMD_POP, 32'h0, 32'h0);

    write_limit(12'd0);
    add_req(tksh_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'd9);

    // limit above capacity
    write_limit(12'hFFF);
    add_req(tksh_pkg::CMD_INSERT, 32'h0001_0000, 32'd10);
    add_req(tksh_pkg::CMD_INSERT, 32'hFFFF_0000, 32'd11);
    add_req(tksh_pkg::CMD_POP, 32'h0, 32'h0);
    add_req(tksh_pkg::CMD_CLEAR, 32'h0, 32'h0);

    while (issued < RANDOM_TARGET) begin
      write_limit(COUNT_W'(limit_plan[phase % limit_plan.size()]));
      quiet_req = ($urandom_range(0, 3) == 0);
      quiet_res = ($urandom_range(0, 3) == 0);
      pop_pct   = $urandom_range(10, 45);
      clear_pct = $urandom_range(0, 1);
      n_items   = $urandom_range(40, 200);
      @(negedge clk_i);
      for (int unsigned i = 0; i < n_items; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < clear_pct) op = tksh_pkg::CMD_CLEAR;
        else if (pick < clear_pct + 3) op = tksh_pkg::CMD_NOP;
        else if (pick < clear_pct + 3 + pop_pct) op = tksh_pkg::CMD_POP;
        else op = tksh_pkg::CMD_INSERT;
        add_req(op, rand_score(), $urandom);
        issued++;
      end
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("run covered %0d requests over %0d limit settings: %0d inserts kept, %0d pops hit",
             req_count, cfg_writes, kept_count, pop_hits);
    $display("largest heap %0d entries, %0d results checked, %0d mismatches",
             max_held, res_count, err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tksh_pkg.sv
rtl/tksh_bank.sv
rtl/tksh_ctrl.sv
rtl/top_k_score_heap_top.sv
dv/tb_top.sv
